// ----- design/ctfc_pkg.sv -----
package ctfc_pkg;

  localparam int OSC_W    = 26;
  localparam int HZ_W     = 32;
  localparam int FACT_W   = 9;
  localparam int DIV_W    = 4;
  localparam int EXP_W    = 3;
  localparam int CODE_W   = 4;
  localparam int WORK_W   = OSC_W + FACT_W;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERNAL_OSC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTERNAL_OSC = 2'd1;

  localparam logic [OSC_W-1:0] OSC_RESET_HZ = 26'd8000000;

  // system clock source codes
  localparam logic [1:0] SRC_INTERNAL = 2'd0;
  localparam logic [1:0] SRC_EXTERNAL = 2'd1;
  localparam logic [1:0] SRC_PLL      = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DIV  = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  localparam logic [FACT_W-1:0] BOOST_FACTOR = 9'd6;

  typedef struct packed {
    logic [1:0]        source_select;
    logic              internal_boost_path;
    logic              internal_boost_div;
    logic              pll_ref_external;
    logic              pll_flexible_mode;
    logic [3:0]        mult_low;
    logic [1:0]        mult_high;
    logic              external_halve;
    logic [DIV_W-1:0]  pre_divider;
    logic [FACT_W-1:0] feedback_mult;
    logic [EXP_W-1:0]  post_div_exp;
    logic [CODE_W-1:0] ahb_prescale_code;
  } ctfc_in_t;

  typedef struct packed {
    logic [HZ_W-1:0] system_hz;
    logic [HZ_W-1:0] bus_hz;
    logic [1:0]      status;
  } ctfc_out_t;

  // one slot of the divider chain
  typedef struct packed {
    logic              valid;
    logic [WORK_W-1:0] work;
    logic [DIV_W-1:0]  rem;
    logic [DIV_W-1:0]  div;
    logic              zero;
    logic [CODE_W-1:0] code;
  } ctfc_pipe_t;

  // AHB prescaler code to right shift
  function automatic logic [3:0] ahb_shift(input logic [CODE_W-1:0] code);
    logic [3:0] sh;
    case (code)
      4'd8:    sh = 4'd1;
      4'd9:    sh = 4'd2;
      4'd10:   sh = 4'd3;
      4'd11:   sh = 4'd4;
      4'd12:   sh = 4'd6;
      4'd13:   sh = 4'd7;
      4'd14:   sh = 4'd8;
      4'd15:   sh = 4'd9;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

// ----- design/ctfc_front.sv -----
module ctfc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  ctfc_pkg::ctfc_in_t          in_data,
  input  logic [ctfc_pkg::OSC_W-1:0]  internal_osc_hz,
  input  logic [ctfc_pkg::OSC_W-1:0]  external_osc_hz,
  output ctfc_pkg::ctfc_pipe_t        head
);
  import ctfc_pkg::*;

  logic [OSC_W-1:0]  ref_hz;
  logic [OSC_W-1:0]  pll_ref;
  logic [FACT_W-1:0] factor;
  logic [6:0]        legacy_mult;
  logic              flex;
  logic [WORK_W-1:0] prod;

  logic              valid;
  logic [WORK_W-1:0] prod_q;
  logic [EXP_W-1:0]  shift_q;
  logic [DIV_W-1:0]  div_q;
  logic              zero_q;
  logic [CODE_W-1:0] code_q;

  // pll reference and legacy multiplier decode
  always_comb begin
    if (!in_data.pll_ref_external) begin
      pll_ref = internal_osc_hz >> 1;
    end else if (in_data.external_halve) begin
      pll_ref = external_osc_hz >> 1;
    end else begin
      pll_ref = external_osc_hz;
    end
    if (in_data.mult_high != 2'd0 || in_data.mult_low == 4'd15) begin
      legacy_mult = {1'b0, in_data.mult_high, in_data.mult_low} + 7'd1;
    end else begin
      legacy_mult = {1'b0, in_data.mult_high, in_data.mult_low} + 7'd2;
    end
  end

  assign flex = (in_data.source_select == SRC_PLL) && in_data.pll_flexible_mode;

  // source select: reference rate and its multiplier
  always_comb begin
    case (in_data.source_select)
      SRC_INTERNAL: begin
        ref_hz = internal_osc_hz;
        factor = (in_data.internal_boost_path && in_data.internal_boost_div) ?
                 BOOST_FACTOR : FACT_W'(1);
      end
      SRC_EXTERNAL: begin
        ref_hz = external_osc_hz;
        factor = FACT_W'(1);
      end
      SRC_PLL: begin
        ref_hz = pll_ref;
        factor = in_data.pll_flexible_mode ? in_data.feedback_mult :
                 FACT_W'(legacy_mult);
      end
      default: begin
        ref_hz = internal_osc_hz;
        factor = FACT_W'(1);
      end
    endcase
  end

  assign prod = {{FACT_W{1'b0}}, ref_hz} * {{OSC_W{1'b0}}, factor};

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q  <= prod;
      shift_q <= flex ? in_data.post_div_exp : EXP_W'(0);
      div_q   <= flex ? in_data.pre_divider : DIV_W'(1);
      zero_q  <= flex && (in_data.pre_divider == DIV_W'(0));
      code_q  <= in_data.ahb_prescale_code;
    end
  end

  // post divider as a shift ahead of the divider chain
  assign head.valid = valid;
  assign head.work  = prod_q >> shift_q;
  assign head.rem   = DIV_W'(0);
  assign head.div   = div_q;
  assign head.zero  = zero_q;
  assign head.code  = code_q;

endmodule

// ----- design/ctfc_div_cell.sv -----
module ctfc_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctfc_pkg::ctfc_pipe_t prev,
  output ctfc_pkg::ctfc_pipe_t next
);
  import ctfc_pkg::*;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             qbit;
  ctfc_pipe_t       next_d;

  // one restoring division step: one quotient bit
  always_comb begin
    trial  = {prev.rem, prev.work[WORK_W-1]};
    diff   = trial - {1'b0, prev.div};
    qbit   = trial >= {1'b0, prev.div};
    next_d = prev;
    next_d.rem  = qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    next_d.work = {prev.work[WORK_W-2:0], qbit};
  end

  // cell register: only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= next_d.valid;
    end
    if (en) begin
      next.work <= next_d.work;
      next.rem  <= next_d.rem;
      next.div  <= next_d.div;
      next.zero <= next_d.zero;
      next.code <= next_d.code;
    end
  end

endmodule

// ----- design/ctfc_out.sv -----
module ctfc_out (
  input  logic                 clk,
  input  logic                 rst,
  input  ctfc_pkg::ctfc_pipe_t tail,
  output logic                 en,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ctfc_pkg::ctfc_out_t  out_data
);
  import ctfc_pkg::*;

  ctfc_out_t res;
  logic      arrive;
  logic      skid_valid;
  ctfc_out_t skid_data;

  // saturation, zero divider and bus prescaler
  always_comb begin
    if (tail.zero) begin
      res.system_hz = '0;
      res.status    = STATUS_ZERO_DIV;
    end else if (tail.work[WORK_W-1:HZ_W] != '0) begin
      res.system_hz = '1;
      res.status    = STATUS_SATURATED;
    end else begin
      res.system_hz = tail.work[HZ_W-1:0];
      res.status    = STATUS_OK;
    end
    res.bus_hz = res.system_hz >> ahb_shift(tail.code);
  end

  assign en     = !skid_valid;
  assign arrive = tail.valid && en;

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= arrive;
      end
    end else if (arrive) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (arrive) begin
        out_data <= res;
      end
    end else if (arrive) begin
      skid_data <= res;
    end
  end

endmodule

// ----- design/clock_tree_frequency_calc.sv -----
// channel  | direction | handshake                  | payload
// in       | input     | in_valid / in_ready        | in_data (ctfc_in_t)
// out      | output    | out_valid / out_ready      | out_data (ctfc_out_t)
// cfg      | input     | cfg_we (no wait)           | cfg_index, cfg_data
//
// one transaction per cycle while the skid entry is empty; the path runs through the product register, one
// cell per quotient bit of the 35-bit divider chain, and the output register.
// rst is synchronous: it empties the pipeline and loads 8 MHz into both
// oscillator registers.
// a stalled output holds one result in the skid entry, then freezes the whole
// chain and drops in_ready until the skid entry drains.
module clock_tree_frequency_calc (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ctfc_pkg::ctfc_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ctfc_pkg::ctfc_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [ctfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctfc_pkg::OSC_W-1:0]        cfg_data
);
  import ctfc_pkg::*;

  logic [OSC_W-1:0] internal_osc_hz;
  logic [OSC_W-1:0] external_osc_hz;
  logic             en;
  ctfc_pipe_t       chain [0:WORK_W];

  // oscillator rate registers
  always_ff @(posedge clk) begin
    if (rst) begin
      internal_osc_hz <= OSC_RESET_HZ;
      external_osc_hz <= OSC_RESET_HZ;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERNAL_OSC: internal_osc_hz <= cfg_data;
        REG_EXTERNAL_OSC: external_osc_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = en;

  ctfc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (in_valid),
    .in_data         (in_data),
    .internal_osc_hz (internal_osc_hz),
    .external_osc_hz (external_osc_hz),
    .head            (chain[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < WORK_W; i++) begin : g_cell
    ctfc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (chain[i]),
      .next (chain[i+1])
    );
  end

  ctfc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .tail      (chain[WORK_W]),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/ctfc_checker.sv -----
module ctfc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input ctfc_pkg::ctfc_out_t out_data
);
  import ctfc_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // zero pre-divider gives zero rates
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_ZERO_DIV |->
      out_data.system_hz == '0 && out_data.bus_hz == '0)
    else $error("zero divider result not zero");

  // saturation pins the system clock at its maximum
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_SATURATED |-> out_data.system_hz == '1)
    else $error("saturated status without full scale");

  // the bus clock never runs faster than the system clock, and the status is a defined code
  a_bus_le_sys: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.bus_hz <= out_data.system_hz &&
      out_data.status <= STATUS_SATURATED)
    else $error("bus clock above system clock or bad status");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind clock_tree_frequency_calc ctfc_checker u_ctfc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- sim/tb_clock_tree_frequency_calc.sv -----
`timescale 1ns / 1ps
module tb_clock_tree_frequency_calc;
  import ctfc_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0]           SRC_OTHER   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // prescaler code to bus shift, four bits per code, code 0 in the low nibble
  localparam logic [63:0] BUS_SHIFT_TABLE =
    {4'd9, 4'd8, 4'd7, 4'd6, 4'd4, 4'd3, 4'd2, 4'd1, 32'd0};
  localparam logic [63:0] HZ_LIMIT            = 64'hFFFF_FFFF;
  localparam logic [63:0] INTERNAL_BOOST_MULT = 64'd6;
  localparam logic [OSC_W-1:0] OSC_TOP_HZ     = 26'd50000000;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_LATENCY   = 40;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int RANDOM_PHASES   = 10;

  // expected clock rates, worked out from each accepted snapshot
  class clock_rate_ledger;
    logic [63:0] internal_hz;
    logic [63:0] external_hz;
    ctfc_out_t   expected_rates[$];
    int          failures;

    function new();
      internal_hz = 64'd8000000;
      external_hz = 64'd8000000;
      failures    = 0;
    endfunction

    function void set_osc(logic [CFG_IDX_W-1:0] idx, logic [OSC_W-1:0] value);
      if (idx == REG_INTERNAL_OSC) internal_hz = {38'd0, value};
      else if (idx == REG_EXTERNAL_OSC) external_hz = {38'd0, value};
    endfunction

    function ctfc_out_t predict_rates(ctfc_in_t snap);
      logic [63:0] sys_hz, ref_hz, mult, lo, hi, ns, divisor;
      logic [1:0]  st;
      ctfc_out_t   rates;
      sys_hz  = '0;
      st      = STATUS_OK;
      lo      = {60'd0, snap.mult_low};
      hi      = {62'd0, snap.mult_high};
      ns      = {55'd0, snap.feedback_mult};
      divisor = {60'd0, snap.pre_divider} << snap.post_div_exp;
      // pll reference: halved internal, or external optionally halved
      if (!snap.pll_ref_external) ref_hz = internal_hz >> 1;
      else if (snap.external_halve) ref_hz = external_hz >> 1;
      else ref_hz = external_hz;
      case (snap.source_select)
        SRC_INTERNAL: begin
          if (snap.internal_boost_path && snap.internal_boost_div)
            sys_hz = internal_hz * INTERNAL_BOOST_MULT;
          else
            sys_hz = internal_hz;
        end
        SRC_EXTERNAL: sys_hz = external_hz;
        SRC_PLL: begin
          if (!snap.pll_flexible_mode) begin
            if (hi != 0 || lo == 64'd15) mult = lo + 64'd16 * hi + 64'd1;
            else mult = lo + 64'd2;
            sys_hz = ref_hz * mult;
          end else if (snap.pre_divider == '0) begin
            st = STATUS_ZERO_DIV;
          end else begin
            sys_hz = (ref_hz * ns) / divisor;
          end
        end
        // other source: plain internal rate, boost ignored
        default: sys_hz = internal_hz;
      endcase
      if (st == STATUS_OK && sys_hz > HZ_LIMIT) begin
        sys_hz = HZ_LIMIT;
        st     = STATUS_SATURATED;
      end
      rates.system_hz = sys_hz[HZ_W-1:0];
      rates.bus_hz    = sys_hz[HZ_W-1:0] >> BUS_SHIFT_TABLE[snap.ahb_prescale_code*4 +: 4];
      rates.status    = st;
      return rates;
    endfunction

    function void note_snapshot(ctfc_in_t snap);
      expected_rates.push_back(predict_rates(snap));
    endfunction

    function void check_rates(ctfc_out_t got);
      ctfc_out_t want;
      if (expected_rates.size() == 0) begin
        $error("unexpected result: system_hz %0d bus_hz %0d status %0d",
               got.system_hz, got.bus_hz, got.status);
        failures++;
        return;
      end
      want = expected_rates.pop_front();
      if (got.system_hz !== want.system_hz) begin
        $error("system_hz: expected %0d, got %0d", want.system_hz, got.system_hz);
        failures++;
      end
      if (got.bus_hz !== want.bus_hz) begin
        $error("bus_hz: expected %0d, got %0d", want.bus_hz, got.bus_hz);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_rates.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  ctfc_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ctfc_out_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OSC_W-1:0]     cfg_data  = '0;

  bit quiet       = 1'b0;
  int ready_hold  = 0;
  int idle_cycles = 0;

  clock_rate_ledger ledger = new();

  clock_tree_frequency_calc u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random, in bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // record config writes, accepted snapshots and results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) ledger.set_osc(cfg_index, cfg_data);
      if (in_valid && in_ready) ledger.note_snapshot(in_data);
      if (out_valid && out_ready) ledger.check_rates(out_data);
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic ctfc_in_t random_snapshot();
    ctfc_in_t    snap;
    logic [63:0] raw;
    raw  = {$urandom, $urandom};
    snap = raw[$bits(ctfc_in_t)-1:0];
    // lean toward the pll, and now and then toward a large flexible ratio
    if ($urandom_range(0, 1) == 0) snap.source_select = SRC_PLL;
    if ($urandom_range(0, 7) == 0) begin
      snap.pre_divider      = 4'd1;
      snap.post_div_exp     = '0;
      snap.feedback_mult[8] = 1'b1;
    end
    return snap;
  endfunction

  task automatic send_snapshot(input ctfc_in_t snap);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      in_data  <= random_snapshot();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= snap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off the sender until every expected result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_oscillators(input logic [OSC_W-1:0] int_hz,
                                   input logic [OSC_W-1:0] ext_hz);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_INTERNAL_OSC;
    cfg_data  <= int_hz;
    @(posedge clk);
    cfg_index <= REG_EXTERNAL_OSC;
    cfg_data  <= ext_hz;
    @(posedge clk);
    // spare indexes must leave both oscillators alone
    cfg_index <= REG_SPARE_A;
    cfg_data  <= OSC_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_SPARE_B;
    cfg_data  <= OSC_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    ctfc_in_t snap;
    // internal source with each combination of boost bits
    snap = '0;
    snap.source_select = SRC_INTERNAL;
    send_snapshot(snap);
    snap.internal_boost_path = 1'b1; snap.ahb_prescale_code = 4'd1;
    send_snapshot(snap);
    snap.internal_boost_path = 1'b0; snap.internal_boost_div = 1'b1;
    snap.ahb_prescale_code = 4'd2;
    send_snapshot(snap);
    snap.internal_boost_path = 1'b1; snap.ahb_prescale_code = 4'd8;
    send_snapshot(snap);
    // other source ignores the boost bits
    snap.source_select = SRC_OTHER; snap.ahb_prescale_code = 4'd9;
    send_snapshot(snap);
    snap = '0;
    snap.source_select = SRC_EXTERNAL; snap.ahb_prescale_code = 4'd15;
    send_snapshot(snap);
    // legacy pll around the multiplier decode boundary
    snap = '0;
    snap.source_select = SRC_PLL; snap.ahb_prescale_code = 4'd10;
    send_snapshot(snap);
    snap.mult_low = 4'd14; snap.ahb_prescale_code = 4'd11;
    send_snapshot(snap);
    snap.mult_low = 4'd15; snap.ahb_prescale_code = 4'd12;
    send_snapshot(snap);
    snap.mult_low = 4'd0; snap.mult_high = 2'd1; snap.ahb_prescale_code = 4'd13;
    send_snapshot(snap);
    snap.pll_ref_external = 1'b1; snap.mult_low = 4'd15; snap.mult_high = 2'd3;
    snap.ahb_prescale_code = 4'd14;
    send_snapshot(snap);
    snap.external_halve = 1'b1;
    send_snapshot(snap);
    // flexible pll: zero pre-divider, then ratio extremes
    snap = '0;
    snap.source_select = SRC_PLL; snap.pll_flexible_mode = 1'b1;
    snap.pll_ref_external = 1'b1; snap.feedback_mult = '1; snap.ahb_prescale_code = 4'd3;
    send_snapshot(snap);
    snap.pre_divider = 4'd1; snap.ahb_prescale_code = 4'd4;
    send_snapshot(snap);
    snap.pre_divider = 4'd15; snap.post_div_exp = 3'd7; snap.feedback_mult = 9'd1;
    snap.ahb_prescale_code = 4'd5;
    send_snapshot(snap);
    snap.pre_divider = 4'd3; snap.post_div_exp = 3'd2; snap.feedback_mult = 9'd100;
    snap.pll_ref_external = 1'b0; snap.ahb_prescale_code = 4'd6;
    send_snapshot(snap);
    // largest oscillators push the flexible pll past 32 bits
    write_oscillators('1, '1);
    snap = '0;
    snap.source_select = SRC_PLL; snap.pll_flexible_mode = 1'b1;
    snap.pll_ref_external = 1'b1; snap.pre_divider = 4'd1; snap.feedback_mult = '1;
    snap.ahb_prescale_code = 4'd15;
    send_snapshot(snap);
    snap.feedback_mult = '0; snap.ahb_prescale_code = 4'd7;
    send_snapshot(snap);
    snap.pll_flexible_mode = 1'b0; snap.mult_low = 4'd15; snap.mult_high = 2'd3;
    send_snapshot(snap);
    snap = '0;
    snap.internal_boost_path = 1'b1; snap.internal_boost_div = 1'b1;
    send_snapshot(snap);
    // zeroed oscillators give zero rates
    write_oscillators('0, '0);
    send_snapshot(snap);
    snap.source_select = SRC_PLL; snap.mult_high = 2'd2;
    send_snapshot(snap);
    snap.pll_flexible_mode = 1'b1; snap.ahb_prescale_code = 4'd12;
    send_snapshot(snap);
  endtask

  initial begin
    logic [OSC_W-1:0] int_hz, ext_hz;
    int               phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    // random phases, each under its own oscillator setting
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin int_hz = OSC_RESET_HZ; ext_hz = OSC_RESET_HZ; end
        1: begin int_hz = 26'd1; ext_hz = 26'd1; end
        2: begin int_hz = OSC_TOP_HZ; ext_hz = OSC_TOP_HZ; end
        3: begin int_hz = '1; ext_hz = '1; end
        4: begin int_hz = '0; ext_hz = OSC_TOP_HZ; end
        5: begin int_hz = OSC_TOP_HZ; ext_hz = 26'd1; end
        default: begin
          int_hz = OSC_W'($urandom_range(1, 50000000));
          if ($urandom_range(0, 3) == 0) ext_hz = OSC_W'($urandom);
          else ext_hz = OSC_W'($urandom_range(1, 50000000));
        end
      endcase
      write_oscillators(int_hz, ext_hz);
      // no idling on either side in the last phase
      if (phase == RANDOM_PHASES - 1) quiet <= 1'b1;
      repeat (ITEMS_PER_PHASE) send_snapshot(random_snapshot());
    end
    wait_for_results();
    repeat (DRAIN_LATENCY) @(posedge clk);
    if (ledger.failures == 0 && ledger.outstanding() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/ctfc_pkg.sv
design/ctfc_front.sv
design/ctfc_div_cell.sv
design/ctfc_out.sv
design/clock_tree_frequency_calc.sv
design/ctfc_checker.sv
sim/tb_clock_tree_frequency_calc.sv
